### rtl/msd_pkg.sv
// shared types and constants of the message stream deframer
package msd_pkg;

  localparam int DEF_LONG_SNIPPET  = 512;
  localparam int DEF_SHORT_SNIPPET = 32;
  localparam int DEF_MAX_PAYLOAD   = 1024 * 1024;
  localparam int DEF_QUEUE_DEPTH   = 4;

  localparam int HDR_BYTES = 24;
  localparam int HDR_WORDS = 6;
  localparam int HDR_CW    = $clog2(HDR_BYTES);

  localparam int W_CMD   = 0;
  localparam int W_ARG0  = 1;
  localparam int W_ARG1  = 2;
  localparam int W_LEN   = 3;
  localparam int W_CHECK = 4;
  localparam int W_MAGIC = 5;

  localparam logic [31:0] MAGIC_INVERT = 32'hffff_ffff;

  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_VERBOSE  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_TO_GUEST = 1'd1;

  localparam logic [1:0] EV_PACKET     = 2'd0;
  localparam logic [1:0] EV_SNIPPET    = 2'd1;
  localparam logic [1:0] EV_BAD_HEADER = 2'd2;
  localparam logic [1:0] EV_TOO_LARGE  = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SNIPPET,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic verbose;
    logic to_guest;
  } msd_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } msd_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  snippet_byte;
    logic        packet_last;
    logic [31:0] command_word;
    logic [31:0] first_argument;
    logic [31:0] second_argument;
    logic [31:0] payload_length;
    logic [31:0] payload_check;
    logic [31:0] magic_word;
    logic        direction;
  } msd_out_t;

endpackage

### rtl/msd_front.sv
// byte parser: header gathering, validation, snippet and skip tracking
module msd_front #(
  parameter int LONG_SNIPPET  = msd_pkg::DEF_LONG_SNIPPET,
  parameter int SHORT_SNIPPET = msd_pkg::DEF_SHORT_SNIPPET,
  parameter int MAX_PAYLOAD   = msd_pkg::DEF_MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst,
  input  msd_pkg::msd_cfg_t cfg,
  input  logic              accept,
  input  msd_pkg::msd_in_t  in_item,
  output logic              ev_push,
  output msd_pkg::msd_out_t ev_item
);
  import msd_pkg::*;

  localparam int CAP_MAX = (LONG_SNIPPET > SHORT_SNIPPET) ? LONG_SNIPPET : SHORT_SNIPPET;
  localparam int TW      = $clog2(CAP_MAX + 1);
  localparam int SKW     = $clog2(MAX_PAYLOAD + 1);
  localparam logic [31:0]   MAX_LEN   = 32'(MAX_PAYLOAD);
  localparam logic [TW-1:0] LONG_CAP  = TW'(LONG_SNIPPET);
  localparam logic [TW-1:0] SHORT_CAP = TW'(SHORT_SNIPPET);
  localparam logic [HDR_CW-1:0] HDR_LAST = HDR_CW'(HDR_BYTES - 1);
  localparam logic [SKW-1:0] SKIP_ONE = SKW'(1);

  phase_t phase, phase_next;
  logic sync_lost, sync_lost_next;
  logic [HDR_CW-1:0] hdr_cnt, hdr_cnt_next;
  logic [31:0] hdr [HDR_WORDS];
  logic [TW-1:0] snip_target, snip_target_next;
  logic [TW-1:0] snip_cnt, snip_cnt_next;
  logic [SKW-1:0] skip_rem, skip_rem_next;

  logic [31:0] magic_now;
  logic [31:0] len_now;
  logic [TW-1:0] cap;
  logic [TW-1:0] snip_cnt_inc;
  logic [1:0] kind;
  logic [7:0] snip_byte;
  logic last;

  assign len_now      = hdr[W_LEN];
  assign magic_now    = (phase == PH_HEADER) ? {in_item.data_byte, hdr[W_MAGIC][23:0]}
                                             : hdr[W_MAGIC];
  assign cap          = cfg.verbose ? LONG_CAP : SHORT_CAP;
  assign snip_cnt_inc = snip_cnt + TW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_lost   <= 1'b0;
      hdr_cnt     <= '0;
      snip_target <= '0;
      snip_cnt    <= '0;
      skip_rem    <= '0;
    end else begin
      sync_lost   <= sync_lost_next;
      hdr_cnt     <= hdr_cnt_next;
      snip_target <= snip_target_next;
      snip_cnt    <= snip_cnt_next;
      skip_rem    <= skip_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !sync_lost && phase == PH_HEADER) begin
      hdr[hdr_cnt[HDR_CW-1:2]][{hdr_cnt[1:0], 3'b000} +: 8] <= in_item.data_byte;
    end
  end

  always_comb begin
    phase_next       = phase;
    sync_lost_next   = sync_lost;
    hdr_cnt_next     = hdr_cnt;
    snip_target_next = snip_target;
    snip_cnt_next    = snip_cnt;
    skip_rem_next    = skip_rem;
    ev_push          = 1'b0;
    kind             = EV_PACKET;
    snip_byte        = 8'd0;
    last             = 1'b0;
    if (accept && !sync_lost) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_cnt == HDR_LAST) begin
            hdr_cnt_next = '0;
            if ((magic_now ^ MAGIC_INVERT) != hdr[W_CMD]) begin
              sync_lost_next = 1'b1;
              ev_push        = 1'b1;
              kind           = EV_BAD_HEADER;
              last           = 1'b1;
            end else if (len_now > MAX_LEN) begin
              sync_lost_next = 1'b1;
              ev_push        = 1'b1;
              kind           = EV_TOO_LARGE;
              last           = 1'b1;
            end else if (len_now == 32'd0) begin
              ev_push = 1'b1;
              kind    = EV_PACKET;
              last    = 1'b1;
            end else begin
              snip_target_next = (len_now < 32'(cap)) ? len_now[TW-1:0] : cap;
              snip_cnt_next    = '0;
              phase_next       = PH_SNIPPET;
            end
          end else begin
            hdr_cnt_next = hdr_cnt + HDR_CW'(1);
          end
        end
        PH_SNIPPET: begin
          snip_cnt_next = snip_cnt_inc;
          ev_push       = 1'b1;
          kind          = EV_SNIPPET;
          snip_byte     = in_item.data_byte;
          last          = (snip_cnt_inc >= snip_target);
          if (last) begin
            if (len_now > 32'(snip_target)) begin
              skip_rem_next = SKW'(len_now - 32'(snip_target));
              phase_next    = PH_SKIP;
            end else begin
              phase_next = PH_HEADER;
            end
          end
        end
        default: begin
          if (skip_rem != '0) begin
            skip_rem_next = skip_rem - SKIP_ONE;
          end
          if (skip_rem <= SKIP_ONE) begin
            phase_next = PH_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    ev_item.event_kind      = kind;
    ev_item.snippet_byte    = snip_byte;
    ev_item.packet_last     = last;
    ev_item.command_word    = hdr[W_CMD];
    ev_item.first_argument  = hdr[W_ARG0];
    ev_item.second_argument = hdr[W_ARG1];
    ev_item.payload_length  = len_now;
    ev_item.payload_check   = hdr[W_CHECK];
    ev_item.magic_word      = magic_now;
    ev_item.direction       = cfg.to_guest;
  end

`ifndef SYNTH
  a_sync_sticky: assert property (@(posedge clk) disable iff (rst)
    sync_lost |=> sync_lost)
    else $error("sync lost flag cleared without reset");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_rem != '0)
    else $error("skip phase with nothing left to skip");

  a_snip_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SNIPPET |-> snip_cnt < snip_target)
    else $error("snippet count reached target inside snippet phase");
`endif

endmodule

### rtl/msd_queue.sv
// result queue between the parser and the result ports
module msd_queue #(
  parameter int DEPTH = msd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  msd_pkg::msd_out_t item_in,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output msd_pkg::msd_out_t item_out
);
  import msd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  msd_out_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  assign full     = (count == DEPTH_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("queue count beyond depth");
`endif

endmodule

### rtl/message_stream_deframer_top.sv
// top level of the message stream deframer
// Takes one stream byte per cycle, with no gaps needed: each byte is handled in
// the cycle it is accepted and any result it causes enters a result queue of
// QUEUE_DEPTH entries, showing on the result ports from the next cycle. full
// rises only while that queue is full, so the rate on the input is one byte per
// cycle for as long as results are popped as fast as they are made. A 24-byte
// header gives at most one result, on its last byte; each snippet byte gives one
// result; skipped payload bytes give none. After a bad header or an oversized
// length the block drops every byte and gives no result until reset.
module message_stream_deframer_top #(
  parameter int LONG_SNIPPET  = msd_pkg::DEF_LONG_SNIPPET,
  parameter int SHORT_SNIPPET = msd_pkg::DEF_SHORT_SNIPPET,
  parameter int MAX_PAYLOAD   = msd_pkg::DEF_MAX_PAYLOAD,
  parameter int QUEUE_DEPTH   = msd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  msd_pkg::msd_in_t           in_item,
  output logic                       empty,
  input  logic                       pop,
  output msd_pkg::msd_out_t          out_item,
  input  logic                       cfg_we,
  input  logic [msd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic                       cfg_wdata
);
  import msd_pkg::*;

  msd_cfg_t cfg;
  logic     accept;
  logic     ev_push;
  msd_out_t ev_item;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_VERBOSE) begin
        cfg.verbose <= cfg_wdata;
      end else if (cfg_addr == REG_TO_GUEST) begin
        cfg.to_guest <= cfg_wdata;
      end
    end
  end

  msd_front #(
    .LONG_SNIPPET (LONG_SNIPPET),
    .SHORT_SNIPPET(SHORT_SNIPPET),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .in_item(in_item),
    .ev_push(ev_push),
    .ev_item(ev_item)
  );

  msd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (ev_push),
    .item_in (ev_item),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .item_out(out_item)
  );

endmodule
